// ===== hdl/pgp_pkg.sv =====
// Shared constants, angle table and handshake types for the panel geometry block.
package pgp_pkg;

  localparam int PT_W         = 18;               // point coordinate width
  localparam int DIFF_W       = PT_W + 1;         // end minus start
  localparam int LEN_W        = 19;               // panel length width
  localparam int ANG_W        = 16;               // panel angle width
  localparam int ACC_W        = 32;               // turn accumulator width
  localparam int GUARD_BITS   = 8;
  localparam int XW           = DIFF_W + GUARD_BITS + 3;
  localparam int MAX_TABLE    = 30;
  localparam int STEP_W       = $clog2(MAX_TABLE);
  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 18;
  localparam longint GAIN_Q30 = 64'd652032874;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
  localparam logic [ACC_W-1:0] TURN_ATAN [MAX_TABLE] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // Commands from the panel sequencer to the vectoring unit.
  typedef struct packed {
    logic start;
    logic ack;
  } pgp_cmd_t;

endpackage

// ===== hdl/pgp_cordic.sv =====
// Iterative CORDIC vectoring unit with gain correction: length and angle of one vector.
module pgp_cordic
  import pgp_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pgp_cmd_t                 cmd,
  input  logic signed [DIFF_W-1:0] dx,
  input  logic signed [DIFF_W-1:0] dy,
  output logic                     done,
  output logic [LEN_W-1:0]         length,
  output logic [ANG_W-1:0]         angle
);

  localparam int NumSteps = (CORDIC_STEPS < MAX_TABLE) ? CORDIC_STEPS : MAX_TABLE;
  localparam logic [STEP_W-1:0] LastStep = STEP_W'(NumSteps - 1);
  localparam int PW = XW - 1 + FRAC_BITS;
  localparam int SH = GUARD_BITS + FRAC_BITS;
  localparam longint GainFull =
    (GAIN_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  localparam logic [FRAC_BITS-1:0] Gain = FRAC_BITS'(GainFull);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_ROT  = 3'd1;
  localparam logic [2:0] C_MUL  = 3'd2;
  localparam logic [2:0] C_RND  = 3'd3;
  localparam logic [2:0] C_DONE = 3'd4;

  logic [2:0]              state;
  logic [STEP_W-1:0]       step;
  logic signed [XW-1:0]    x;
  logic signed [XW-1:0]    y;
  logic [ACC_W-1:0]        acc;
  logic [PW-1:0]           prod;

  logic signed [XW-1:0]    x_init;
  logic signed [XW-1:0]    y_init;
  logic signed [XW-1:0]    xs;
  logic signed [XW-1:0]    ys;
  logic [XW-2:0]           x_pos;
  logic [PW:0]             rnd_sum;
  logic [PW-SH:0]          len_full;
  logic [ACC_W-1:0]        ang_sum;

  assign x_init = {{(XW-DIFF_W-GUARD_BITS){dx[DIFF_W-1]}}, dx, {GUARD_BITS{1'b0}}};
  assign y_init = {{(XW-DIFF_W-GUARD_BITS){dy[DIFF_W-1]}}, dy, {GUARD_BITS{1'b0}}};
  assign xs     = x >>> step;
  assign ys     = y >>> step;
  assign x_pos  = x[XW-1] ? '0 : x[XW-2:0];
  assign rnd_sum  = {1'b0, prod} + ((PW+1)'(1) << (SH - 1));
  assign len_full = rnd_sum[PW:SH];
  assign ang_sum  = acc + (ACC_W'(1) << (ACC_W - ANG_W - 1));
  assign done     = (state == C_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (cmd.start) begin
            step <= '0;
            if (dx == '0 && dy == '0) begin
              // A zero-length vector skips the rotations and gives zeros.
              x     <= '0;
              y     <= '0;
              acc   <= '0;
              state <= C_MUL;
            end else begin
              if (dx[DIFF_W-1]) begin
                x   <= -x_init;
                y   <= -y_init;
                acc <= ACC_W'(1) << (ACC_W - 1);
              end else begin
                x   <= x_init;
                y   <= y_init;
                acc <= '0;
              end
              state <= C_ROT;
            end
          end
        end
        C_ROT: begin
          if (!y[XW-1]) begin
            x   <= x + ys;
            y   <= y - xs;
            acc <= acc + TURN_ATAN[step];
          end else begin
            x   <= x - ys;
            y   <= y + xs;
            acc <= acc - TURN_ATAN[step];
          end
          step <= step + 1'b1;
          if (step == LastStep) begin
            state <= C_MUL;
          end
        end
        C_MUL: begin
          prod  <= PW'(x_pos) * PW'(Gain);
          state <= C_RND;
        end
        C_RND: begin
          length <= (len_full > (PW-SH+1)'(LEN_MAX)) ? LEN_MAX : LEN_W'(len_full);
          angle  <= ang_sum[ACC_W-1 -: ANG_W];
          state  <= C_DONE;
        end
        C_DONE: begin
          if (cmd.ack) begin
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/panel_geometry_from_points_top.sv =====
// Top level: outline points in, panels with end points, midpoint, length and angle out.
//
// Usage. Outline points arrive on the input channel (in_valid, in_stall,
// point_x, point_y, list_start) and panels leave on the output channel
// (out_valid, out_stall and the panel fields). An item moves when valid is
// high and stall is low at a rising clock edge.
// A point with list_start set, or the first point after reset, is only
// stored as the previous point and yields no panel.
// Every other point yields one panel built from the previous point and it.
// Each panel passes through the single CORDIC vectoring unit, which performs
// one micro-rotation per cycle for CORDIC_STEPS steps (capped at 30 steps),
// then a multiply and a rounding step for gain correction, and then into the
// output register. A new point is not taken while a panel is being computed:
// in_stall stays high until the panel has moved into the output register.
// The output register parts the two sides: a new point is taken while a
// finished panel waits. If the receiver stalls, the next panel stays in the
// vectoring unit until the output register frees up, and in_stall stays high.
// Reset (rst, synchronous) clears the previous point and empties the block.
module panel_geometry_from_points_top
  import pgp_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [PT_W-1:0]  point_x,
  input  logic signed [PT_W-1:0]  point_y,
  input  logic                    list_start,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PT_W-1:0]  start_x,
  output logic signed [PT_W-1:0]  start_y,
  output logic signed [PT_W-1:0]  end_x,
  output logic signed [PT_W-1:0]  end_y,
  output logic signed [PT_W-1:0]  mid_x,
  output logic signed [PT_W-1:0]  mid_y,
  output logic [LEN_W-1:0]        panel_length,
  output logic [ANG_W-1:0]        panel_angle
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                    state;
  logic                    have_prev;
  logic signed [PT_W-1:0]  prev_x;
  logic signed [PT_W-1:0]  prev_y;

  // Panel fields held while the vectoring unit runs.
  logic signed [PT_W-1:0]  pan_sx;
  logic signed [PT_W-1:0]  pan_sy;
  logic signed [PT_W-1:0]  pan_ex;
  logic signed [PT_W-1:0]  pan_ey;
  logic signed [PT_W-1:0]  pan_mx;
  logic signed [PT_W-1:0]  pan_my;

  logic                    in_take;
  logic                    make_panel;
  logic                    out_free;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] sum_x;
  logic signed [DIFF_W-1:0] sum_y;
  pgp_cmd_t                cmd;
  logic                    cordic_done;
  logic [LEN_W-1:0]        cordic_len;
  logic [ANG_W-1:0]        cordic_ang;

  assign in_stall   = (state != ST_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign make_panel = in_take && !list_start && have_prev;
  assign out_free   = !out_valid || !out_stall;

  // Differences and sums are one bit wider than the points; the midpoint is
  // the sum shifted right, which rounds toward minus infinity.
  assign dx    = {point_x[PT_W-1], point_x} - {prev_x[PT_W-1], prev_x};
  assign dy    = {point_y[PT_W-1], point_y} - {prev_y[PT_W-1], prev_y};
  assign sum_x = {point_x[PT_W-1], point_x} + {prev_x[PT_W-1], prev_x};
  assign sum_y = {point_y[PT_W-1], point_y} + {prev_y[PT_W-1], prev_y};

  assign cmd.start = make_panel;
  assign cmd.ack   = (state == ST_BUSY) && cordic_done && out_free;

  pgp_cordic #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .dx     (dx),
    .dy     (dy),
    .done   (cordic_done),
    .length (cordic_len),
    .angle  (cordic_ang)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      have_prev <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        prev_x    <= point_x;
        prev_y    <= point_y;
        have_prev <= 1'b1;
      end
      if (make_panel) begin
        pan_sx <= prev_x;
        pan_sy <= prev_y;
        pan_ex <= point_x;
        pan_ey <= point_y;
        pan_mx <= sum_x[DIFF_W-1:1];
        pan_my <= sum_y[DIFF_W-1:1];
        state  <= ST_BUSY;
      end
      if (cmd.ack) begin
        start_x      <= pan_sx;
        start_y      <= pan_sy;
        end_x        <= pan_ex;
        end_y        <= pan_ey;
        mid_x        <= pan_mx;
        mid_y        <= pan_my;
        panel_length <= cordic_len;
        panel_angle  <= cordic_ang;
        out_valid    <= 1'b1;
        state        <= ST_IDLE;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== dv/tb_panel_geometry_from_points_top.sv =====
// Self-checking testbench for the outline point to panel geometry block.
`timescale 1ns / 1ps

module tb_panel_geometry_from_points_top;
  import pgp_pkg::*;

  // The block runs at its default sizes: 16 fraction bits, 18 micro-rotations.
  localparam int CORDIC_ITERS = 18;
  localparam int LATENCY = CORDIC_ITERS + 4;
  localparam int GUARD_SHIFT = 8;
  localparam int FRAC_SHIFT = 16;

  // Gain correction 0.60725293500888 taken from 30 fraction bits down to 16, rounded.
  localparam longint GAIN_Q16 = (64'd652032874 + 64'd8192) >> 14;
  localparam longint LEN_CAP = 524287;

  // atan(2^-i) as a fraction of a full turn scaled by 2^32, for the steps that run.
  localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F
  };

  localparam int RANDOM_ITEMS = 1425;
  localparam int QUIET_LIMIT = 2000;   // cycles with no item moving on either side
  localparam int PRESSURE_AT = 150;    // the receiver holds off before this panel
  localparam int PRESSURE_HOLD = 300;
  localparam int MAX_REPORTS = 40;

  // One directed point. The zero_len column types in the length and angle of a
  // panel whose two ends coincide: both are zero.
  typedef struct packed {
    logic [PT_W-1:0] x;
    logic [PT_W-1:0] y;
    logic ls;
    logic zero_len;
  } dir_row_t;

  // Edge values: 1FFFF is the largest coordinate, 20000 the smallest, 3FFFF is -1.
  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{18'h00000, 18'h00000, 1'b0, 1'b0},  // first point after reset: stored only
    '{18'h00000, 18'h00000, 1'b0, 1'b1},  // panel of zero length
    '{18'h1FFFF, 18'h00000, 1'b0, 1'b0},  // along +x, largest x coordinate
    '{18'h20000, 18'h00000, 1'b0, 1'b0},  // along -x, most negative dx
    '{18'h20000, 18'h1FFFF, 1'b0, 1'b0},  // along +y, largest y coordinate
    '{18'h20000, 18'h20000, 1'b0, 1'b0},  // along -y, most negative dy
    '{18'h1FFFF, 18'h1FFFF, 1'b0, 1'b0},  // longest diagonal
    '{18'h20000, 18'h20000, 1'b0, 1'b0},  // and back
    '{18'h20000, 18'h20000, 1'b0, 1'b1},  // zero length at the corner
    '{18'h00005, 18'h00003, 1'b1, 1'b0},  // new outline
    '{18'h00006, 18'h00003, 1'b0, 1'b0},  // unit steps around a square
    '{18'h00006, 18'h00004, 1'b0, 1'b0},
    '{18'h00005, 18'h00004, 1'b0, 1'b0},
    '{18'h00005, 18'h00003, 1'b0, 1'b0},
    '{18'h3FFFF, 18'h3FFFF, 1'b1, 1'b0},  // new outline at (-1, -1)
    '{18'h00000, 18'h00000, 1'b0, 1'b0},  // midpoint of -1 and 0 floors to -1
    '{18'h1FFFF, 18'h20000, 1'b1, 1'b0},
    '{18'h20000, 18'h1FFFF, 1'b0, 1'b0},  // up and to the left
    '{18'h1FFFF, 18'h20000, 1'b0, 1'b0},  // down and to the right
    '{18'h1FFFF, 18'h20000, 1'b0, 1'b1},
    '{18'h20000, 18'h00000, 1'b1, 1'b0},
    '{18'h1FFFF, 18'h3FFFF, 1'b0, 1'b0},  // just below +x: angle rounds up to 0
    '{18'h00000, 18'h00001, 1'b1, 1'b0},
    '{18'h00000, 18'h00001, 1'b1, 1'b0},  // two outline starts in a row
    '{18'h00000, 18'h3FFFF, 1'b0, 1'b0}
  };

  typedef struct {
    logic signed [PT_W-1:0] sx;
    logic signed [PT_W-1:0] sy;
    logic signed [PT_W-1:0] ex;
    logic signed [PT_W-1:0] ey;
    logic signed [PT_W-1:0] mx;
    logic signed [PT_W-1:0] my;
    logic [LEN_W-1:0] len;
    logic [ANG_W-1:0] ang;
  } panel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [PT_W-1:0] point_x = '0;
  logic signed [PT_W-1:0] point_y = '0;
  logic list_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [PT_W-1:0] start_x;
  logic signed [PT_W-1:0] start_y;
  logic signed [PT_W-1:0] end_x;
  logic signed [PT_W-1:0] end_y;
  logic signed [PT_W-1:0] mid_x;
  logic signed [PT_W-1:0] mid_y;
  logic [LEN_W-1:0] panel_length;
  logic [ANG_W-1:0] panel_angle;

  // Our own copy of the previous outline point.
  logic signed [PT_W-1:0] last_x = '0;
  logic signed [PT_W-1:0] last_y = '0;
  bit have_last = 1'b0;

  panel_t panel_q[$];     // panels still owed by the block, oldest first
  int fail_count = 0;
  int points_sent = 0;
  int quiet_cycles = 0;

  panel_geometry_from_points_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .list_start   (list_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .mid_x        (mid_x),
    .mid_y        (mid_y),
    .panel_length (panel_length),
    .panel_angle  (panel_angle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Length and angle of the vector (dx, dy) by vectoring CORDIC. The vector is
  // first brought into the right half plane, the turn count starting at half a
  // turn if it was flipped. Each step rotates toward the x axis; x ends up as
  // the length times the CORDIC gain, which the final multiply takes out.
  function automatic void vector_polar(input longint dx, input longint dy,
                                       output logic [LEN_W-1:0] len,
                                       output logic [ANG_W-1:0] ang);
    longint x, y, xs, ys, prod;
    logic [31:0] turns, rounded;
    len = '0;
    ang = '0;
    if (dx == 0 && dy == 0) return;
    x = dx * (longint'(1) << GUARD_SHIFT);
    y = dy * (longint'(1) << GUARD_SHIFT);
    turns = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      turns = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        turns += ATAN_TURN[i];
      end else begin
        x -= ys;
        y += xs;
        turns -= ATAN_TURN[i];
      end
    end
    if (x < 0) x = 0;
    prod = (x * GAIN_Q16 + (longint'(1) << (GUARD_SHIFT + FRAC_SHIFT - 1)))
           >>> (GUARD_SHIFT + FRAC_SHIFT);
    len = (prod > LEN_CAP) ? LEN_CAP[LEN_W-1:0] : prod[LEN_W-1:0];
    // Round to 16 bits of a turn; a value just under a full turn wraps to 0.
    rounded = turns + 32'h0000_8000;
    ang = rounded[31:16];
  endfunction

  // Takes one outline point. Returns 1 with the panel it closes, or 0 when the
  // point only opens an outline (list start, or nothing stored since reset).
  function automatic bit advance_outline(input logic signed [PT_W-1:0] px,
                                         input logic signed [PT_W-1:0] py,
                                         input bit ls, output panel_t p);
    longint sum_x, sum_y;
    if (ls || !have_last) begin
      last_x = px;
      last_y = py;
      have_last = 1'b1;
      return 1'b0;
    end
    sum_x = longint'(last_x) + longint'(px);
    sum_y = longint'(last_y) + longint'(py);
    p.sx = last_x;
    p.sy = last_y;
    p.ex = px;
    p.ey = py;
    p.mx = PT_W'(sum_x >>> 1);
    p.my = PT_W'(sum_y >>> 1);
    vector_polar(longint'(px) - longint'(last_x), longint'(py) - longint'(last_y),
                 p.len, p.ang);
    last_x = px;
    last_y = py;
    return 1'b1;
  endfunction

  // A coordinate for the next point: fully random, a small step from the
  // previous one, an extreme, unchanged, or close to the origin.
  function automatic logic [PT_W-1:0] pick_coord(input logic [PT_W-1:0] base);
    logic [PT_W-1:0] step;
    case ($urandom_range(0, 9))
      0, 1, 2: return PT_W'($urandom_range(0, (1 << PT_W) - 1));
      3, 4, 5: begin
        step = PT_W'($urandom_range(0, 64) - 32);
        return base + step;
      end
      6: return $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
      7: return base;
      default: return PT_W'($urandom_range(0, 8) - 4);
    endcase
  endfunction

  function automatic void check_field(input string name, input longint want_v,
                                      input longint got_v);
    if (want_v != got_v) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endfunction

  // Offers one point after a random gap and holds it until it is taken; the
  // owed panel, if any, is queued at the edge where the item moves. During
  // every third stretch of 150 items the sender offers back to back.
  task automatic send_point(input logic [PT_W-1:0] x, input logic [PT_W-1:0] y,
                            input bit ls, input bit typed_zero);
    panel_t p;
    int gap;
    gap = (((points_sent / 150) % 3) == 2) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    list_start <= ls;
    do @(posedge clk); while (in_stall);
    if (advance_outline(x, y, ls, p)) begin
      if (typed_zero) begin
        p.len = '0;
        p.ang = '0;
      end
      panel_q.push_back(p);
    end
    points_sent++;
  endtask

  // Receiver. For each panel it draws how long to stall once the panel is
  // offered; with a hold of zero the stall is already low, so the panel moves
  // on the first edge it is valid. Once, it holds off for a long stretch while
  // the sender keeps offering, which fills the block and raises in_stall.
  initial begin : receiver
    int hold;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == PRESSURE_AT) hold = PRESSURE_HOLD;
      else if (((taken / 60) % 3) == 2) hold = 0;
      else hold = $urandom_range(0, 12);
      if (hold == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Every panel that moves is compared field by field with the oldest one owed.
  always @(posedge clk) begin : panel_check
    panel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (panel_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected panel, expected none, got (%0d,%0d)-(%0d,%0d)",
                   $time, start_x, start_y, end_x, end_y);
      end else begin
        want = panel_q.pop_front();
        check_field("start_x", want.sx, start_x);
        check_field("start_y", want.sy, start_y);
        check_field("end_x", want.ex, end_x);
        check_field("end_y", want.ey, end_y);
        check_field("mid_x", want.mx, mid_x);
        check_field("mid_y", want.my, mid_y);
        check_field("panel_length", want.len, panel_length);
        check_field("panel_angle", want.ang, panel_angle);
      end
    end
  end

  // Watchdog: a hung block or a lost panel shows up as a long spell in which
  // no item moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int left_in_outline;
    bit ls;
    logic [PT_W-1:0] nx, ny;
    left_in_outline = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extremes of both coordinates, all four axis directions,
    // zero-length panels, midpoint rounding, and the points that give no panel.
    for (int r = 0; r < DIR_ROWS; r++)
      send_point(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].ls, DIRECTED[r].zero_len);

    // Random part: outlines of 2 to 41 points, each opened by a list start,
    // with a stray list start now and then and the odd repeated point.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (left_in_outline == 0) begin
        ls = 1'b1;
        left_in_outline = $urandom_range(1, 40);
      end else begin
        ls = ($urandom_range(0, 49) == 0);
        left_in_outline--;
      end
      if ($urandom_range(0, 29) == 0) begin
        nx = last_x;
        ny = last_y;
      end else begin
        nx = pick_coord(last_x);
        ny = pick_coord(last_y);
      end
      send_point(nx, ny, ls, 1'b0);
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed panel, then a while longer for strays.
    while (panel_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pgp_pkg.sv
hdl/pgp_cordic.sv
hdl/panel_geometry_from_points_top.sv
dv/tb_panel_geometry_from_points_top.sv
